// ===== hw/rtl/orve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package orve_pkg;

  // varint code register, three 7-bit groups, wide enough for the id code plus spare group bits
  localparam int CODE_W = 21;

  // varint group mask and continuation flag
  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] MORE_FLAG  = 8'h80;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_MISS  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/object_reference_varint_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                             | handshake
// --------- | ------------------------------------------------- | ------------------------
// request   | object_key                                        | start high, busy low
// result    | out_byte, last_byte, is_new, object_id, table_full | strobe high, one cycle
//
// a request is taken from idle; the key table is searched one entry at a
// time, each a memory read (FETCH) then a compare in the shared comparator
// (CMP); the search stops at a hit or after the last stored entry, and an
// empty table goes straight to a miss; then one byte per cycle, one to three bytes
// rst is synchronous and clears only the sequencer and the id count
// the receiver cannot stall: each result byte is shown for exactly one cycle

module object_reference_varint_encoder_core
  import orve_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] object_key,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             is_new,
  output logic [7:0]       object_id,
  output logic             table_full
);

  localparam int IDW  = $clog2(TABLE_DEPTH);
  localparam int CNTW = IDW + 1;

  state_t               state;
  logic [CNTW-1:0]      next_id;
  logic [IDW-1:0]       idx;
  logic [KEY_WIDTH-1:0] key;
  logic [KEY_WIDTH-1:0] rd_data;
  logic [IDW-1:0]       id;
  logic [CODE_W-1:0]    code;
  logic                 fresh;
  logic                 full;

  logic [KEY_WIDTH-1:0] key_store [TABLE_DEPTH];

  logic accept;
  logic hit;
  logic last_entry;
  logic table_is_full;
  logic more;
  logic mem_we;

  assign accept        = start && !busy;
  assign busy          = (state != ST_IDLE);
  assign hit           = (rd_data == key);
  assign last_entry    = ((CNTW'(idx) + CNTW'(1)) == next_id);
  assign table_is_full = (next_id == CNTW'(TABLE_DEPTH));
  assign more          = (code[CODE_W-1:7] != '0);
  assign mem_we        = (state == ST_MISS) && !table_is_full;

  // key table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_store[next_id[IDW-1:0]] <= key;
    end
    rd_data <= key_store[idx];
  end

  // sequencer and id count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      next_id <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= (next_id == '0) ? ST_MISS : ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (hit) begin
            state <= ST_EMIT;
          end else if (last_entry) begin
            state <= ST_MISS;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_MISS: begin
          if (!table_is_full) begin
            next_id <= next_id + CNTW'(1);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!more) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload: key, search index, id, varint code and the new and full flags
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key <= object_key[KEY_WIDTH-1:0];
        idx <= '0;
      end
      ST_CMP: begin
        if (hit) begin
          id    <= idx;
          code  <= CODE_W'({idx, 1'b0});
          fresh <= 1'b0;
          full  <= 1'b0;
        end else if (!last_entry) begin
          idx <= idx + IDW'(1);
        end
      end
      ST_MISS: begin
        if (table_is_full) begin
          id    <= '0;
          code  <= '0;
          fresh <= 1'b0;
          full  <= 1'b1;
        end else begin
          id    <= next_id[IDW-1:0];
          code  <= CODE_W'({next_id[IDW-1:0], 1'b1});
          fresh <= 1'b1;
          full  <= 1'b0;
        end
      end
      ST_EMIT: begin
        code <= code >> 7;
      end
      default: begin
      end
    endcase
  end

  // result bytes
  assign strobe     = (state == ST_EMIT);
  assign out_byte   = (code[7:0] & GROUP_MASK) | (more ? MORE_FLAG : 8'h00);
  assign last_byte  = !more;
  assign is_new     = fresh;
  assign object_id  = 8'(id);
  assign table_full = full;

  // a new request is taken only with a free sequencer and keeps it busy
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request accepted but block not busy");

  // bytes of one code come in consecutive cycles
  assert property (@(posedge clk) disable iff (rst) (strobe && !last_byte) |=> strobe)
    else $error("gap inside a varint code");

  // the full result is a single zero byte, given only with a full table
  assert property (@(posedge clk) disable iff (rst)
    (strobe && table_full) |-> (last_byte && out_byte == 8'h00 && table_is_full))
    else $error("bad table full result");

  // a newly stored key always carries an odd code on its first byte
  assert property (@(posedge clk) disable iff (rst)
    ($rose(strobe) && is_new) |-> out_byte[0])
    else $error("new key without odd code");

  // the id count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) next_id <= CNTW'(TABLE_DEPTH))
    else $error("id count past table depth");

endmodule

`default_nettype wire
